// File: hw/rtl/cie_pkg.sv
// Shared types and constants for the CSR instruction execute core.
// No dependencies; the access check and the top level import it.
package cie_pkg;

  // Operation codes carried on the request tuser
  localparam logic [2:0] CMD_RW  = 3'd0;
  localparam logic [2:0] CMD_RS  = 3'd1;
  localparam logic [2:0] CMD_RC  = 3'd2;
  localparam logic [2:0] CMD_RWI = 3'd3;
  localparam logic [2:0] CMD_RSI = 3'd4;
  localparam logic [2:0] CMD_RCI = 3'd5;

  // Privilege modes
  localparam logic [1:0] MODE_USER  = 2'd0;
  localparam logic [1:0] MODE_SUPER = 2'd1;
  localparam logic [1:0] MODE_RSVD  = 2'd2;
  localparam logic [1:0] MODE_MACH  = 2'd3;

  // Level needed by an address range
  localparam logic [1:0] LVL_USER  = 2'd0;
  localparam logic [1:0] LVL_SUPER = 2'd1;
  localparam logic [1:0] LVL_OPEN  = 2'd2;
  localparam logic [1:0] LVL_MACH  = 2'd3;

  localparam logic [11:0] ADDR_SATP       = 12'h180;
  localparam logic [11:0] ADDR_ID_LO      = 12'hF11;
  localparam logic [11:0] ADDR_ID_HI      = 12'hF15;
  localparam logic [11:0] ADDR_CNT_LO     = 12'hC00;
  localparam logic [11:0] ADDR_CNT_HI     = 12'hC1F;
  localparam logic [11:0] ADDR_CNTH_LO    = 12'hC80;
  localparam logic [11:0] ADDR_CNTH_HI    = 12'hC9F;

  // Fields the access check looks at
  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] addr;
    logic [1:0]  mode;
    logic        tvm;
    logic        src_nonzero;
  } access_req_t;

  // Verdict of the access check
  typedef struct packed {
    logic illegal;
    logic write;
  } access_resp_t;

endpackage

// File: hw/rtl/cie_access_check.sv
// Privilege and write-permission check for one CSR instruction.
// Depends on cie_pkg for the request and verdict structs and codes.
module cie_access_check import cie_pkg::*; (
  input  access_req_t  req,
  output access_resp_t resp
);

  logic [1:0] level;
  logic       allowed;
  logic       read_only;
  logic       cmd_ok;
  logic       write;

  // decode the operation into a write decision
  always_comb begin
    cmd_ok = 1'b1;
    write  = 1'b0;
    unique case (req.cmd) inside
      CMD_RW, CMD_RWI: write = 1'b1;
      CMD_RS, CMD_RC, CMD_RSI, CMD_RCI: write = req.src_nonzero;
      default: cmd_ok = 1'b0;
    endcase
  end

  always_comb begin
    unique case (req.addr[11:8])
      4'h0:    level = LVL_USER;
      4'h1:    level = LVL_SUPER;
      4'h2:    level = LVL_OPEN;
      4'h3:    level = LVL_MACH;
      4'hB:    level = LVL_MACH;
      4'hF:    level = LVL_MACH;
      default: level = LVL_USER;
    endcase
  end

  // reserved mode ranks below user: only the open range
  always_comb begin
    if (level == LVL_OPEN) begin
      allowed = 1'b1;
    end else begin
      unique case (req.mode)
        MODE_MACH:  allowed = 1'b1;
        MODE_SUPER: allowed = (level == LVL_USER) || (level == LVL_SUPER);
        MODE_USER:  allowed = (level == LVL_USER);
        default:    allowed = 1'b0;
      endcase
    end
  end

  assign read_only = (req.addr >= ADDR_ID_LO   && req.addr <= ADDR_ID_HI)   ||
                     (req.addr >= ADDR_CNT_LO  && req.addr <= ADDR_CNT_HI)  ||
                     (req.addr >= ADDR_CNTH_LO && req.addr <= ADDR_CNTH_HI);

  assign resp.write   = write;
  assign resp.illegal = !cmd_ok ||
                        (req.mode == MODE_SUPER && req.tvm && req.addr == ADDR_SATP) ||
                        !allowed ||
                        (write && read_only);

endmodule

// File: hw/rtl/csr_instruction_execute_core.sv
// Top level of the CSR instruction execute core: request and result streams.
// Depends on cie_pkg and instantiates cie_access_check.
//
//  Channel    | Direction | Handshake                    | Contents
//  s_axis_*   | in        | s_axis_tvalid / s_axis_tready | one CSR instruction request
//  m_axis_*   | out       | m_axis_tvalid / m_axis_tready | trap flag, CSR and rd writes
//
// Two register stages: the request register, then the result register with the
// access check and new-value logic between them. One request per cycle is
// sustained while the result side does not stall; a result is presented from the result register.
// rst (synchronous, active high) empties both stages; payload is not reset.
// A stall on the result side holds the result register and, once the request
// register is also full, drops s_axis_tready; nothing is lost or repeated.
module csr_instruction_execute_core import cie_pkg::*; #(
  parameter  int XLEN     = 64,
  localparam int IN_BITS  = 57 + 2 * XLEN,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 34 + 2 * XLEN,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata, lowest bit up: addr[12], priv_mode[2], tvm[1], src_index[5],
  // src_value[XLEN], rd_index[5], csr_old_value[XLEN], instr_word[32], zero fill
  input  logic [IN_W-1:0]     s_axis_tdata,
  // tuser: cmd[3]
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata, lowest bit up: trap_value[32], csr_write_enable[1],
  // csr_write_value[XLEN], rd_write_enable[1], rd_value[XLEN], zero fill
  output logic [OUT_W-1:0]    m_axis_tdata,
  // tuser: illegal[1]
  output logic                m_axis_tuser
);

  // request field offsets
  localparam int O_MODE = 12;
  localparam int O_TVM  = 14;
  localparam int O_SRC  = 15;
  localparam int O_SRCV = 20;
  localparam int O_RD   = O_SRCV + XLEN;
  localparam int O_OLD  = O_RD + 5;
  localparam int O_WORD = O_OLD + XLEN;

  // request register
  logic              req_valid;
  logic [2:0]        req_cmd;
  logic [11:0]       req_addr;
  logic [1:0]        req_mode;
  logic              req_tvm;
  logic [4:0]        req_src;
  logic [XLEN-1:0]   req_srcv;
  logic [4:0]        req_rd;
  logic [XLEN-1:0]   req_old;
  logic [31:0]       req_word;

  // result register
  logic              res_valid;
  logic              res_illegal;
  logic [31:0]       res_trap;
  logic              res_cwe;
  logic [XLEN-1:0]   res_cwv;
  logic              res_rwe;
  logic [XLEN-1:0]   res_rdv;

  logic              advance;
  access_req_t       chk_req;
  access_resp_t      chk_resp;
  logic [XLEN-1:0]   operand;
  logic [XLEN-1:0]   new_value;

  // advance the pipeline whenever the result register is free or being taken
  assign advance       = !res_valid || m_axis_tready;
  assign s_axis_tready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (s_axis_tready) begin
      req_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_cmd  <= s_axis_tuser;
      req_addr <= s_axis_tdata[11:0];
      req_mode <= s_axis_tdata[O_MODE +: 2];
      req_tvm  <= s_axis_tdata[O_TVM];
      req_src  <= s_axis_tdata[O_SRC +: 5];
      req_srcv <= s_axis_tdata[O_SRCV +: XLEN];
      req_rd   <= s_axis_tdata[O_RD +: 5];
      req_old  <= s_axis_tdata[O_OLD +: XLEN];
      req_word <= s_axis_tdata[O_WORD +: 32];
    end
  end

  assign chk_req.cmd         = req_cmd;
  assign chk_req.addr        = req_addr;
  assign chk_req.mode        = req_mode;
  assign chk_req.tvm         = req_tvm;
  assign chk_req.src_nonzero = (req_src != 5'd0);

  cie_access_check u_check (
    .req  (chk_req),
    .resp (chk_resp)
  );

  // immediate forms take the zero-extended index as operand
  assign operand = (req_cmd == CMD_RWI || req_cmd == CMD_RSI || req_cmd == CMD_RCI) ?
                   {{(XLEN-5){1'b0}}, req_src} : req_srcv;

  always_comb begin
    case (req_cmd) inside
      CMD_RW, CMD_RWI: new_value = operand;
      CMD_RS, CMD_RSI: new_value = req_old | operand;
      default:         new_value = req_old & ~operand;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= req_valid;
    end
  end

  // on a trap, zero every write and hand back the instruction word
  always_ff @(posedge clk) begin
    if (advance && req_valid) begin
      res_illegal <= chk_resp.illegal;
      res_trap    <= chk_resp.illegal ? req_word : 32'd0;
      res_cwe     <= !chk_resp.illegal && chk_resp.write;
      res_cwv     <= (!chk_resp.illegal && chk_resp.write) ? new_value : '0;
      res_rwe     <= !chk_resp.illegal && (req_rd != 5'd0);
      res_rdv     <= chk_resp.illegal ? '0 : req_old;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_illegal;
  assign m_axis_tdata  = OUT_W'({res_rdv, res_rwe, res_cwv, res_cwe, res_trap});

  // a trapped instruction writes nothing
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (!res_cwe && !res_rwe && res_rdv == '0))
    else $error("trap result carries a write");

  // a result with no CSR write carries a zero write value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !res_cwe) |-> (res_cwv == '0))
    else $error("CSR write value without write enable");

  // a legal result reports no trap value
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (res_trap == 32'd0))
    else $error("trap value on a legal result");

  // a request waiting behind a stalled result stays put
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !advance) |=> (req_valid && $stable(req_word) && $stable(req_cmd)))
    else $error("request register changed under stall");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for csr_instruction_execute_core: directed and random CSR instruction requests.
// Depends on cie_pkg and the core RTL; predicts each result and checks it on the result stream.
module tb_top;
  import cie_pkg::*;

  localparam int XLEN = 64;
  // Request tdata: addr, mode, tvm, src index, src value, rd, old value, word, padded to bytes
  localparam int IN_W = ((12 + 2 + 1 + 5 + XLEN + 5 + XLEN + 32 + 7) / 8) * 8;
  // Result tdata: trap value, csr we, csr value, rd we, rd value, padded to bytes
  localparam int OUT_W = ((32 + 1 + XLEN + 1 + XLEN + 7) / 8) * 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = 8;

  // Operation codes the core does not define; both must trap
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [11:0]     addr;
    logic [1:0]      mode;
    logic            tvm;
    logic [4:0]      src_idx;
    logic [XLEN-1:0] src_val;
    logic [4:0]      rd_idx;
    logic [XLEN-1:0] old_val;
    logic [31:0]     word;
  } csr_req_t;

  typedef struct packed {
    logic            illegal;
    logic [31:0]     trap_value;
    logic            csr_we;
    logic [XLEN-1:0] csr_wv;
    logic            rd_we;
    logic [XLEN-1:0] rd_val;
  } csr_res_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [2:0]       s_axis_tuser = CMD_RW;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tuser;

  csr_res_t pending_results [$];
  csr_res_t got_res;
  csr_res_t want_res;
  int       failures = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  csr_instruction_execute_core #(.XLEN(XLEN)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Access rules
  // ---------------------------------------------------------------------------

  // Lowest privilege an address range admits
  function automatic logic [1:0] required_level(input logic [11:0] a);
    if (a <= 12'h0FF) return LVL_USER;
    if (a <= 12'h1FF) return LVL_SUPER;
    if (a <= 12'h2FF) return LVL_OPEN;
    if (a <= 12'h3FF) return LVL_MACH;
    if (a >= 12'hB00 && a <= 12'hBFF) return LVL_MACH;
    if (a >= 12'hC00 && a <= 12'hCFF) return LVL_USER;
    if (a >= 12'hF00) return LVL_MACH;
    return LVL_USER;
  endfunction

  // Reserved mode ranks below user: it only reaches the open range
  function automatic logic mode_reaches(input logic [1:0] need, input logic [1:0] mode);
    if (need == LVL_OPEN) return 1'b1;
    case (mode)
      MODE_MACH:  return 1'b1;
      MODE_SUPER: return need == LVL_USER || need == LVL_SUPER;
      MODE_USER:  return need == LVL_USER;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic logic is_read_only(input logic [11:0] a);
    return (a >= ADDR_ID_LO && a <= ADDR_ID_HI) ||
           (a >= ADDR_CNT_LO && a <= ADDR_CNT_HI) ||
           (a >= ADDR_CNTH_LO && a <= ADDR_CNTH_HI);
  endfunction

  // Work out the trap verdict, CSR write and rd write for one instruction
  function automatic csr_res_t predict_csr_result(input csr_req_t r);
    csr_res_t        res;
    logic            trap;
    logic            writes;
    logic [XLEN-1:0] operand;
    logic [XLEN-1:0] new_val;
    res = '0;
    trap = 1'b0;
    writes = 1'b0;
    new_val = '0;
    if (r.cmd > CMD_RCI) begin
      trap = 1'b1;
    end else begin
      // Immediate forms take the index field itself, zero-extended
      operand = (r.cmd >= CMD_RWI) ? XLEN'(r.src_idx) : r.src_val;
      case (r.cmd)
        CMD_RW, CMD_RWI: begin
          writes = 1'b1;
          new_val = operand;
        end
        CMD_RS, CMD_RSI: begin
          writes = r.src_idx != 5'd0;
          new_val = r.old_val | operand;
        end
        default: begin
          writes = r.src_idx != 5'd0;
          new_val = r.old_val & ~operand;
        end
      endcase
      if (r.mode == MODE_SUPER && r.tvm && r.addr == ADDR_SATP)
        trap = 1'b1;
      else if (!mode_reaches(required_level(r.addr), r.mode))
        trap = 1'b1;
      else if (writes && is_read_only(r.addr))
        trap = 1'b1;
    end
    if (trap) begin
      res.illegal = 1'b1;
      res.trap_value = r.word;
    end else begin
      res.csr_we = writes;
      res.csr_wv = writes ? new_val : '0;
      res.rd_we = r.rd_idx != 5'd0;
      res.rd_val = r.old_val;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic csr_req_t make_req(input logic [2:0] cmd, input logic [11:0] addr,
                                        input logic [1:0] mode, input logic tvm,
                                        input logic [4:0] src_idx,
                                        input logic [XLEN-1:0] src_val,
                                        input logic [4:0] rd_idx,
                                        input logic [XLEN-1:0] old_val,
                                        input logic [31:0] word);
    csr_req_t r;
    r.cmd = cmd;
    r.addr = addr;
    r.mode = mode;
    r.tvm = tvm;
    r.src_idx = src_idx;
    r.src_val = src_val;
    r.rd_idx = rd_idx;
    r.old_val = old_val;
    r.word = word;
    return r;
  endfunction

  // Entered and left at a falling edge. Idle at random first, then hold the
  // request until the core takes it, and record its expected result.
  task automatic send_request(input csr_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = r.cmd;
    s_axis_tdata = IN_W'({r.word, r.old_val, r.rd_idx, r.src_val, r.src_idx,
                          r.tvm, r.mode, r.addr});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(predict_csr_result(r));
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Stall the result stream at the current rate; decided at each falling edge
  always @(negedge clk) begin
    m_axis_tready = $urandom_range(99) >= recv_idle_pct;
  end

  task automatic check_field(input string name, input logic [XLEN-1:0] want,
                             input logic [XLEN-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      failures++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.illegal = m_axis_tuser;
      got_res.trap_value = m_axis_tdata[31:0];
      got_res.csr_we = m_axis_tdata[32];
      got_res.csr_wv = m_axis_tdata[32+XLEN:33];
      got_res.rd_we = m_axis_tdata[33+XLEN];
      got_res.rd_val = m_axis_tdata[33+2*XLEN:34+XLEN];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("illegal", XLEN'(want_res.illegal), XLEN'(got_res.illegal));
        check_field("trap_value", XLEN'(want_res.trap_value), XLEN'(got_res.trap_value));
        check_field("csr_write_enable", XLEN'(want_res.csr_we), XLEN'(got_res.csr_we));
        check_field("csr_write_value", want_res.csr_wv, got_res.csr_wv);
        check_field("rd_write_enable", XLEN'(want_res.rd_we), XLEN'(got_res.rd_we));
        check_field("rd_value", want_res.rd_val, got_res.rd_val);
      end
    end
  end

  // Abandon a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation, both undefined codes, and the extremes of the data fields
  task automatic test_operations();
    send_request(make_req(CMD_RW, 12'h340, MODE_MACH, 1'b0, 5'd31, '1, 5'd31, '0, '1));
    send_request(make_req(CMD_RS, 12'h340, MODE_MACH, 1'b1, 5'd1, 64'h00FF_00FF_00FF_00FF,
                          5'd1, 64'hF0F0_F0F0_F0F0_F0F0, 32'h0000_0000));
    send_request(make_req(CMD_RC, 12'h340, MODE_MACH, 1'b0, 5'd31, 64'h8000_0000_0000_0001,
                          5'd31, '1, 32'h1234_5678));
    send_request(make_req(CMD_RWI, 12'h340, MODE_MACH, 1'b0, 5'd31, '1, 5'd7, '1, '1));
    send_request(make_req(CMD_RSI, 12'h340, MODE_MACH, 1'b0, 5'd0, '1, 5'd31, '1, '1));
    send_request(make_req(CMD_RCI, 12'h340, MODE_MACH, 1'b0, 5'd31, '0, 5'd0, '1, '1));
    send_request(make_req(CMD_UNDEF_LO, 12'h340, MODE_MACH, 1'b0, 5'd3, '1, 5'd3, '1, '1));
    send_request(make_req(CMD_UNDEF_HI, 12'h000, MODE_MACH, 1'b0, 5'd0, '0, 5'd0, '0,
                          32'hDEAD_BEEF));
  endtask

  // Range edges against each mode, the reserved mode included
  task automatic test_privilege_ranges();
    send_request(make_req(CMD_RS, 12'h0FF, MODE_USER, 1'b0, 5'd0, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RW, 12'h100, MODE_USER, 1'b0, 5'd2, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RW, 12'h1FF, MODE_SUPER, 1'b0, 5'd2, '1, 5'd5, '0, '1));
    send_request(make_req(CMD_RS, 12'h300, MODE_SUPER, 1'b0, 5'd0, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RW, 12'h2FF, MODE_RSVD, 1'b0, 5'd4, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RS, 12'h000, MODE_RSVD, 1'b0, 5'd0, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RW, 12'hBFF, MODE_MACH, 1'b0, 5'd4, '1, 5'd5, '0, '1));
    send_request(make_req(CMD_RW, 12'h7C0, MODE_USER, 1'b0, 5'd4, '1, 5'd5, '1, '1));
    send_request(make_req(CMD_RS, 12'hF00, MODE_SUPER, 1'b0, 5'd0, '1, 5'd5, '1, '1));
  endtask

  // Supervisor access to satp under TVM traps even for a pure read
  task automatic test_satp_trap();
    send_request(make_req(CMD_RS, ADDR_SATP, MODE_SUPER, 1'b1, 5'd0, '1, 5'd9, '1, '1));
    send_request(make_req(CMD_RW, ADDR_SATP, MODE_SUPER, 1'b0, 5'd9, '1, 5'd9, '0, '1));
    send_request(make_req(CMD_RW, ADDR_SATP, MODE_MACH, 1'b1, 5'd9, '1, 5'd9, '0, '1));
  endtask

  // Read-only counters and IDs: a read passes, any write traps; rwi always writes
  task automatic test_read_only_counters();
    send_request(make_req(CMD_RW, ADDR_ID_LO, MODE_MACH, 1'b0, 5'd0, '1, 5'd1, '1, '1));
    send_request(make_req(CMD_RS, ADDR_ID_HI, MODE_MACH, 1'b0, 5'd0, '1, 5'd1, '1, '1));
    send_request(make_req(CMD_RCI, ADDR_CNT_HI, MODE_USER, 1'b0, 5'd0, '1, 5'd1, '1, '1));
    send_request(make_req(CMD_RWI, ADDR_CNTH_LO, MODE_USER, 1'b0, 5'd0, '1, 5'd1, '1, '1));
    send_request(make_req(CMD_RS, ADDR_CNTH_HI, MODE_MACH, 1'b0, 5'd5, '1, 5'd1, '1, '1));
    send_request(make_req(CMD_RW, ADDR_ID_HI + 12'd1, MODE_MACH, 1'b0, 5'd5, '1, 5'd1, '0, '1));
  endtask

  // Favour addresses near range edges and in the special ranges
  function automatic logic [11:0] pick_addr();
    case ($urandom_range(11))
      0:       return ADDR_SATP;
      1:       return ADDR_ID_LO + 12'($urandom_range(4));
      2:       return ADDR_CNT_LO + 12'($urandom_range(31));
      3:       return ADDR_CNTH_LO + 12'($urandom_range(31));
      4:       return 12'h100 + 12'($urandom_range(255));
      5:       return 12'h200 + 12'($urandom_range(255));
      6:       return 12'h300 + 12'($urandom_range(255));
      7:       return 12'hB00 + 12'($urandom_range(255));
      8:       return 12'hF00 + 12'($urandom_range(255));
      9:       return 12'($urandom_range(255));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [XLEN-1:0] pick_data();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic csr_req_t random_request();
    csr_req_t r;
    if ($urandom_range(15) == 0)
      r.cmd = $urandom_range(1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
    else
      r.cmd = 3'($urandom_range(5));
    r.addr = $urandom_range(1) ? pick_addr() : 12'($urandom);
    // Machine mode gets past most checks, so weight it up
    r.mode = ($urandom_range(4) >= 3) ? MODE_MACH : 2'($urandom_range(2));
    r.tvm = 1'($urandom);
    r.src_idx = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom);
    r.src_val = pick_data();
    r.rd_idx = ($urandom_range(7) == 0) ? 5'd0 : 5'($urandom);
    r.old_val = pick_data();
    r.word = $urandom;
    return r;
  endfunction

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_request(random_request());
    // Hold off until the pipeline has emptied
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_operations();
    test_privilege_ranges();
    test_satp_trap();
    test_read_only_counters();
    drain_results();

    test_random_traffic(520, 31, 63);
    test_random_traffic(520, 63, 31);
    test_random_traffic(510, 0, 0);

    // Give any stray result time to show
    recv_idle_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end

endmodule
